// ===== sv/pmd_pkg.sv =====
`default_nettype none
package pmd_pkg;

   // configuration register indexes
   localparam logic REG_WHEEL_ENABLE = 1'b0;
   localparam logic REG_FIVE_BUTTON  = 1'b1;

   // event kinds
   localparam logic KIND_MOTION = 1'b0;
   localparam logic KIND_BUTTON = 1'b1;

   // event codes
   localparam logic [2:0] EV_X      = 3'd0;
   localparam logic [2:0] EV_Y      = 3'd1;
   localparam logic [2:0] EV_WHEEL  = 3'd2;
   localparam logic [2:0] EV_LEFT   = 3'd3;
   localparam logic [2:0] EV_RIGHT  = 3'd4;
   localparam logic [2:0] EV_MIDDLE = 3'd5;
   localparam logic [2:0] EV_SIDE   = 3'd6;
   localparam logic [2:0] EV_EXTRA  = 3'd7;

   // header byte bits
   localparam int HDR_SYNC_BIT  = 3;
   localparam int HDR_XSIGN_BIT = 4;
   localparam int HDR_YSIGN_BIT = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int EVENT_COUNT = 8;

   // one decoded packet: deltas, new button state and which events fire
   typedef struct packed {
      logic signed [8:0] x;
      logic signed [9:0] neg_y;
      logic signed [7:0] z;
      logic [4:0]        buttons;
      logic [EVENT_COUNT-1:0] mask;
   } pmd_desc_type;

endpackage
`default_nettype wire

// ===== sv/pmd_front.sv =====
`default_nettype none
module pmd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic              csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_rx_byte,
   input  wire logic              q_full,
   output logic                   q_push,
   output pmd_pkg::pmd_desc_type  q_push_data
);
   import pmd_pkg::*;

   logic       wheel_ff, wheel_in;
   logic       five_ff, five_in;
   logic [1:0] count_ff, count_in;
   logic [4:0] prev_ff, prev_in;
   logic [7:0] bytes_ff [3];

   logic       accept;
   logic       completes;
   logic       have_w;
   logic [7:0] hdr, xb, yb, wb;
   logic [4:0] buttons;
   logic signed [8:0] x, y;
   logic signed [7:0] z;
   pmd_desc_type desc;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // configuration writes
   always_comb begin
      wheel_in = wheel_ff;
      five_in  = five_ff;
      if (csr_we) begin
         if (csr_index == REG_WHEEL_ENABLE) wheel_in = csr_wdata;
         if (csr_index == REG_FIVE_BUTTON)  five_in  = csr_wdata;
      end
   end

   // packet decode of the completing byte
   always_comb begin
      hdr       = bytes_ff[0];
      xb        = bytes_ff[1];
      have_w    = wheel_ff && (count_ff == 2'd3);
      completes = wheel_ff ? (count_ff == 2'd3) : (count_ff[1] == 1'b1);
      yb        = have_w ? bytes_ff[2] : req_rx_byte;
      wb        = req_rx_byte;
      x         = {hdr[HDR_XSIGN_BIT], xb};
      y         = {hdr[HDR_YSIGN_BIT], yb};
      buttons   = {2'b00, hdr[2:0]};
      z         = 8'sd0;
      if (have_w) begin
         if (five_ff) begin
            z          = {{4{wb[3]}}, wb[3:0]};
            buttons[3] = wb[4];
            buttons[4] = wb[5];
         end else begin
            z = wb;
         end
      end
      desc.x       = x;
      desc.neg_y   = 10'sd0 - {y[8], y};
      desc.z       = z;
      desc.buttons = buttons;
      desc.mask    = {buttons ^ prev_ff, (z != 8'sd0), (y != 9'sd0), (x != 9'sd0)};
   end

   // byte counter and button history
   always_comb begin
      count_in = count_ff;
      prev_in  = prev_ff;
      if (accept) begin
         unique case (count_ff)
            2'd0:    count_in = req_rx_byte[HDR_SYNC_BIT] ? 2'd1 : 2'd0;
            2'd1:    count_in = 2'd2;
            2'd2:    count_in = wheel_ff ? 2'd3 : 2'd0;
            default: count_in = 2'd0;
         endcase
         if (completes) prev_in = buttons;
      end
   end

   assign q_push      = accept && completes && (desc.mask != '0);
   assign q_push_data = desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_ff <= 1'b0;
         five_ff  <= 1'b0;
         count_ff <= 2'd0;
         prev_ff  <= 5'd0;
      end else begin
         wheel_ff <= wheel_in;
         five_ff  <= five_in;
         count_ff <= count_in;
         prev_ff  <= prev_in;
      end
   end

   // packet byte store, written as bytes arrive
   always_ff @(posedge clock) begin
      if (accept) begin
         if (count_ff == 2'd0) bytes_ff[0] <= req_rx_byte;
         if (count_ff == 2'd1) bytes_ff[1] <= req_rx_byte;
         if (count_ff == 2'd2 && wheel_ff) bytes_ff[2] <= req_rx_byte;
      end
   end

endmodule
`default_nettype wire

// ===== sv/pmd_queue.sv =====
`default_nettype none
module pmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire pmd_pkg::pmd_desc_type push_data,
   input  wire logic              pop,
   output logic                   full,
   output logic                   empty,
   output pmd_pkg::pmd_desc_type  head
);
   import pmd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   pmd_desc_type         entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

// ===== sv/pmd_back.sv =====
`default_nettype none
module pmd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire pmd_pkg::pmd_desc_type q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_event_kind,
   output logic [2:0]             rsp_event_code,
   output logic signed [9:0]      rsp_event_value,
   output logic                   rsp_last_event
);
   import pmd_pkg::*;

   logic                    work_valid_ff, work_valid_in;
   pmd_desc_type            work_ff, work_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    kind_ff, kind_in;
   logic [2:0]              code_ff, code_in;
   logic signed [9:0]       value_ff, value_in;
   logic                    last_ff, last_in;

   logic                    out_free, emit, work_free;
   logic [2:0]              sel;
   logic [EVENT_COUNT-1:0]  rem;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = work_valid_ff && out_free;
   assign rem       = work_ff.mask & (work_ff.mask - 1'b1);
   assign work_free = !work_valid_ff || (emit && rem == '0);
   assign q_pop     = work_free && !q_empty;

   // lowest pending event goes first
   always_comb begin
      sel = 3'd0;
      for (int i = EVENT_COUNT - 1; i >= 0; i--) begin
         if (work_ff.mask[i]) sel = 3'(i);
      end
   end

   // event fields for the selected code
   always_comb begin
      code_in = sel;
      last_in = (rem == '0);
      kind_in = KIND_BUTTON;
      unique case (sel)
         EV_X: begin
            kind_in  = KIND_MOTION;
            value_in = {work_ff.x[8], work_ff.x};
         end
         EV_Y: begin
            kind_in  = KIND_MOTION;
            value_in = work_ff.neg_y;
         end
         EV_WHEEL: begin
            kind_in  = KIND_MOTION;
            value_in = {{2{work_ff.z[7]}}, work_ff.z};
         end
         EV_LEFT:   value_in = {9'd0, work_ff.buttons[0]};
         EV_RIGHT:  value_in = {9'd0, work_ff.buttons[1]};
         EV_MIDDLE: value_in = {9'd0, work_ff.buttons[2]};
         EV_SIDE:   value_in = {9'd0, work_ff.buttons[3]};
         EV_EXTRA:  value_in = {9'd0, work_ff.buttons[4]};
         default:   value_in = 10'sd0;
      endcase
   end

   // working packet register
   always_comb begin
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      if (q_pop) begin
         work_in       = q_head;
         work_valid_in = 1'b1;
      end else if (work_free) begin
         work_valid_in = 1'b0;
      end else if (emit) begin
         work_in.mask = rem;
      end
   end

   assign rsp_valid_in = out_free ? emit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (emit) begin
         kind_ff  <= kind_in;
         code_ff  <= code_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_event_code  = code_ff;
   assign rsp_event_value = value_ff;
   assign rsp_last_event  = last_ff;

endmodule
`default_nettype wire

// ===== sv/ps2_mouse_packet_decoder.sv =====
// path: packet queue, then working packet register, then result register
// throughput: one byte per cycle while the two-entry packet queue has room,
// one event per cycle on the result side unless stalled; a packet fires at most
// eight events, so four-byte packets that fire all eight can hold up input
// reset: synchronous, clears registers, byte count, button history and queue
`default_nettype none
module ps2_mouse_packet_decoder (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic         csr_wdata,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_rx_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              rsp_event_kind,
   output logic [2:0]        rsp_event_code,
   output logic signed [9:0] rsp_event_value,
   output logic              rsp_last_event
);
   import pmd_pkg::*;

   logic         q_full, q_empty, q_push, q_pop;
   pmd_desc_type q_push_data, q_head;

   // byte assembly and packet decode
   pmd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // decoded packets waiting for the emitter
   pmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   // event emitter
   pmd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_code  (rsp_event_code),
      .rsp_event_value (rsp_event_value),
      .rsp_last_event  (rsp_last_event)
   );

endmodule
`default_nettype wire

// ===== sv/pmd_checker.sv =====
`default_nettype none
module pmd_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire logic         rsp_event_kind,
   input wire logic [2:0]   rsp_event_code,
   input wire logic [9:0]   rsp_event_value,
   input wire logic         rsp_last_event
);
   import pmd_pkg::*;

   // no item right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_code)
         && $stable(rsp_event_value) && $stable(rsp_last_event))
      else $error("stalled item changed");

   // motion events carry motion codes and a nonzero delta
   a_motion: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == KIND_MOTION |->
         (rsp_event_code == EV_X || rsp_event_code == EV_Y || rsp_event_code == EV_WHEEL)
         && rsp_event_value != 10'd0)
      else $error("bad motion event");

   // button events carry button codes and a 0 or 1 value
   a_button: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == KIND_BUTTON |->
         rsp_event_code != EV_X && rsp_event_code != EV_Y && rsp_event_code != EV_WHEEL
         && (rsp_event_value == 10'd0 || rsp_event_value == 10'd1))
      else $error("bad button event");

   // events of one packet come in rising code order
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_event ##1 rsp_valid |->
         rsp_event_code > $past(rsp_event_code))
      else $error("event order broken");

endmodule

bind ps2_mouse_packet_decoder pmd_checker u_pmd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_event_kind  (rsp_event_kind),
   .rsp_event_code  (rsp_event_code),
   .rsp_event_value (rsp_event_value),
   .rsp_last_event  (rsp_last_event)
);
`default_nettype wire

// ===== verif/tb_ps2_mouse_packet_decoder.sv =====
`timescale 1ns / 100ps
module tb_ps2_mouse_packet_decoder;
   import pmd_pkg::*;

   typedef struct packed {
      logic              kind;
      logic [2:0]        code;
      logic signed [9:0] value;
      logic              last;
   } mouse_event_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic       csr_index = 1'b0;
   logic       csr_wdata = 1'b0;
   logic       req_valid = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_stall = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic              rsp_event_kind;
   logic [2:0]        rsp_event_code;
   logic signed [9:0] rsp_event_value;
   logic              rsp_last_event;

   // decoder state as the predictor sees it
   logic       wheel_on = 1'b0;
   logic       five_on = 1'b0;
   logic [1:0] byte_cnt = 2'd0;
   logic [7:0] pkt_bytes [3];
   logic [4:0] prev_btn = 5'd0;

   mouse_event_type expected_events [$];

   int errors = 0;
   int bytes_sent = 0;
   int bytes_used = 0;
   int packets_done = 0;
   int events_seen = 0;
   int settings_used = 0;
   int hold_off = 0;
   int sink_busy_pct = 0;
   bit send_gaps = 1'b0;

   ps2_mouse_packet_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_code  (rsp_event_code),
      .rsp_event_value (rsp_event_value),
      .rsp_last_event  (rsp_last_event)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 1;
      else if (r < 88) return $urandom_range(2, 4);
      else if (r < 97) return $urandom_range(5, 12);
      else return $urandom_range(20, 60);
   endfunction

   // predict the events caused by one accepted byte; returns 0 if the byte is dropped
   function automatic bit decode_mouse_byte(input logic [7:0] b);
      logic [7:0] hdr, xb, yb, wb;
      logic       have_w;
      int         x, y, z;
      logic [4:0] btn, chg;
      mouse_event_type evs [$];
      wb = 8'h00;
      have_w = 1'b0;
      z = 0;
      if (byte_cnt == 2'd0) begin
         if (!b[HDR_SYNC_BIT]) return 1'b0;
         pkt_bytes[0] = b;
         byte_cnt = 2'd1;
         return 1'b1;
      end
      if (byte_cnt == 2'd1) begin
         pkt_bytes[1] = b;
         byte_cnt = 2'd2;
         return 1'b1;
      end
      if (wheel_on) begin
         if (byte_cnt == 2'd2) begin
            pkt_bytes[2] = b;
            byte_cnt = 2'd3;
            return 1'b1;
         end
         yb = pkt_bytes[2];
         wb = b;
         have_w = 1'b1;
      end else begin
         // also covers a fourth-byte slot left over when the wheel was turned off
         yb = b;
      end
      byte_cnt = 2'd0;
      hdr = pkt_bytes[0];
      xb = pkt_bytes[1];
      x = int'(xb) - (hdr[HDR_XSIGN_BIT] ? 256 : 0);
      y = int'(yb) - (hdr[HDR_YSIGN_BIT] ? 256 : 0);
      btn = {2'b00, hdr[2:0]};
      if (have_w) begin
         if (five_on) begin
            z = int'(wb[3:0]) - (wb[3] ? 16 : 0);
            btn[3] = wb[4];
            btn[4] = wb[5];
         end else begin
            z = int'(wb) - (wb[7] ? 256 : 0);
         end
      end
      if (x != 0) evs.push_back('{KIND_MOTION, EV_X, 10'(x), 1'b0});
      if (y != 0) evs.push_back('{KIND_MOTION, EV_Y, 10'(-y), 1'b0});
      if (z != 0) evs.push_back('{KIND_MOTION, EV_WHEEL, 10'(z), 1'b0});
      chg = btn ^ prev_btn;
      for (int i = 0; i < 5; i++) begin
         if (chg[i]) evs.push_back('{KIND_BUTTON, 3'(EV_LEFT + i), 10'(btn[i]), 1'b0});
      end
      prev_btn = btn;
      if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
      foreach (evs[i]) expected_events.push_back(evs[i]);
      packets_done++;
      return 1'b1;
   endfunction

   // offer one item and wait until it is taken; valid stays high afterwards
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (send_gaps && $urandom_range(0, 2) == 0) gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      bytes_sent++;
      if (decode_mouse_byte(b)) bytes_used++;
   endtask

   // stop offering and let every expected event arrive, then let the pipe settle
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (expected_events.size() != 0 && waited < 20000);
      if (expected_events.size() != 0) begin
         $display("error: %0d expected events never arrived", expected_events.size());
         errors += expected_events.size();
         expected_events.delete();
      end
      repeat (12) @(posedge clock);
   endtask

   // write both registers while the block is idle
   task automatic configure(input logic wheel, input logic five);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= REG_WHEEL_ENABLE;
      csr_wdata <= wheel;
      @(posedge clock);
      wheel_on = wheel;
      csr_index <= REG_FIVE_BUTTON;
      csr_wdata <= five;
      @(posedge clock);
      five_on = five;
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // well-formed packet with random content, biased toward zero deltas and held buttons
   task automatic send_random_packet();
      logic [7:0] hdr, xb, yb, wb;
      hdr = 8'($urandom);
      hdr[HDR_SYNC_BIT] = 1'b1;
      xb = 8'($urandom);
      yb = 8'($urandom);
      wb = 8'($urandom);
      if ($urandom_range(0, 2) == 0) hdr[2:0] = prev_btn[2:0];
      if ($urandom_range(0, 4) == 0) begin
         xb = 8'h00;
         hdr[HDR_XSIGN_BIT] = 1'b0;
      end
      if ($urandom_range(0, 4) == 0) begin
         yb = 8'h00;
         hdr[HDR_YSIGN_BIT] = 1'b0;
      end
      if ($urandom_range(0, 4) == 0) wb = five_on ? {wb[7:4], 4'h0} : 8'h00;
      send_byte(hdr);
      send_byte(xb);
      send_byte(yb);
      if (wheel_on) send_byte(wb);
   endtask

   task automatic random_phase(input int n);
      int start;
      start = bytes_used;
      while (bytes_used - start < n) begin
         if ($urandom_range(0, 7) == 0) send_byte(8'($urandom));
         else send_random_packet();
      end
   endtask

   // dropped headers, full-range deltas, a packet with no events
   task automatic test_basic_packets();
      configure(1'b0, 1'b0);
      send_byte(8'h00);
      send_byte(8'hF7);
      send_byte(8'h3F);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hC8);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h08);
      send_byte(8'h00);
      send_byte(8'h00);
   endtask

   // signed byte wheel, nibble wheel with side and extra, five buttons without wheel
   task automatic test_wheel_modes();
      configure(1'b1, 1'b0);
      send_byte(8'h0C);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h80);
      configure(1'b1, 1'b1);
      send_byte(8'h08);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'h38);
      configure(1'b0, 1'b1);
      send_byte(8'h08);
      send_byte(8'h00);
      send_byte(8'h00);
   endtask

   // three bytes held with the wheel on, then the wheel is turned off
   task automatic test_wheel_off_mid_packet();
      configure(1'b1, 1'b0);
      send_byte(8'h09);
      send_byte(8'h05);
      send_byte(8'h00);
      configure(1'b0, 1'b0);
      send_byte(8'h03);
   endtask

   // random traffic under every setting, with and without idling
   task automatic test_random_traffic();
      configure(1'b0, 1'b0);
      send_gaps = 1'b0;
      sink_busy_pct = 0;
      random_phase(95);
      configure(1'b1, 1'b0);
      send_gaps = 1'b1;
      sink_busy_pct = 30;
      random_phase(95);
      configure(1'b1, 1'b1);
      sink_busy_pct = 50;
      random_phase(95);
      configure(1'b0, 1'b1);
      sink_busy_pct = 20;
      random_phase(95);
   endtask

   // receiver holds off as the sender floods; once drained, five more packets with gaps
   task automatic test_backpressure();
      configure(1'b1, 1'b1);
      send_gaps = 1'b0;
      sink_busy_pct = 0;
      hold_off = 200;
      repeat (12) send_random_packet();
      wait_drained();
      send_gaps = 1'b1;
      sink_busy_pct = 25;
      repeat (5) send_random_packet();
   endtask

   // receiver side: random stall stretches, plus long hold-offs on request
   initial begin : sink_driver
      int n;
      @(posedge clock);
      forever begin
         if (hold_off > 0) begin
            n = hold_off;
            hold_off = 0;
            rsp_stall <= 1'b1;
         end else if (sink_busy_pct > 0 && $urandom_range(0, 99) < sink_busy_pct) begin
            n = idle_length();
            rsp_stall <= 1'b1;
         end else begin
            n = $urandom_range(1, 6);
            rsp_stall <= 1'b0;
         end
         repeat (n) @(posedge clock);
      end
   end

   // compare each accepted event with the oldest expected one
   initial begin : result_monitor
      mouse_event_type exp_ev;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            events_seen++;
            if (expected_events.size() == 0) begin
               if (errors < 10)
                  $display("error: unexpected event kind %0d code %0d value %0d last %0d",
                           rsp_event_kind, rsp_event_code, rsp_event_value, rsp_last_event);
               errors++;
            end else begin
               exp_ev = expected_events.pop_front();
               if (rsp_event_kind !== exp_ev.kind || rsp_event_code !== exp_ev.code ||
                   rsp_event_value !== exp_ev.value || rsp_last_event !== exp_ev.last) begin
                  if (errors < 10)
                     $display("error: expected kind %0d code %0d value %0d last %0d, got %0d %0d %0d %0d",
                              exp_ev.kind, exp_ev.code, exp_ev.value, exp_ev.last,
                              rsp_event_kind, rsp_event_code, rsp_event_value, rsp_last_event);
                  errors++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      #6_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin : main_sequence
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_packets();
      test_wheel_modes();
      test_wheel_off_mid_packet();
      test_random_traffic();
      test_backpressure();
      wait_drained();
      $display("run covered %0d bytes (%0d kept), %0d packets, %0d events",
               bytes_sent, bytes_used, packets_done, events_seen);
      $display("across %0d register settings, including long receiver hold-off", settings_used);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
